@@ sv/cple_pkg.sv @@
package cple_pkg;

  localparam int unsigned PoolDepth = 64;
  localparam int unsigned KeyBits   = 16;
  localparam int unsigned SlotBits  = $clog2(PoolDepth);
  localparam int unsigned CountBits = $clog2(PoolDepth + 1);

  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic [2:0] {
    ActInsFront = 3'd0,
    ActInsBack  = 3'd1,
    ActSelect   = 3'd2,
    ActNext     = 3'd3,
    ActPrev     = 3'd4,
    ActDelete   = 3'd5,
    ActRead     = 3'd6,
    ActSpare    = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StEmpty    = 2'd1,
    StNotFound = 2'd2,
    StFull     = 2'd3
  } status_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpLatch,      // capture request, start free-slot scan
    OpScanStep,   // advance free-slot scan
    OpRdHead,     // read links/key at head
    OpRdCur,      // read links/key at current
    OpRdNode,     // read links/key at walk node
    OpInsEmpty,   // write self-linked node
    OpInsLink1,   // write new node and tail forward
    OpInsLink2,   // write head backward, commit
    OpStepFwd,
    OpStepBwd,
    OpSelHit,
    OpSelMiss,
    OpDelLast,
    OpDelLink1,   // write pred forward
    OpDelLink2    // write succ backward, commit
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       out_load;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic    free_found;
    logic    scan_done;
    logic    empty;
    logic    cur_ok;
    logic    key_match;
    logic    walk_done;
    logic    only_one;
    action_e action;
  } sts_t;

endpackage

@@ sv/circular_playlist_list_engine_core.sv @@
// channel  | valid / ready               | payload
// request  | in_valid_i / in_ready_o     | action_i, song_key_i
// result   | out_valid_o / out_ready_i   | status_o, current_key_o, current_present_o,
//          |                             | entry_count_o
// One request at a time. Insert scans the used bits one a cycle for the first free slot;
// select walks the nodes from the head until a key match or the last node. Reset clears
// used bits, head, current and count; link and key RAMs are not cleared.
// A new request waits until the previous result word has been taken.
module circular_playlist_list_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [15:0] song_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [15:0] current_key_o,
  output logic        current_present_o,
  output logic [6:0]  entry_count_o
);
  import cple_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cple_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd));

  cple_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .action_i, .song_key_i, .sts_o(sts),
    .status_o, .current_key_o, .current_present_o, .entry_count_o);
endmodule

@@ sv/cple_ram.sv @@
module cple_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/cple_datapath.sv @@
module cple_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cple_pkg::cmd_t        cmd_i,
  input  logic [2:0]            action_i,
  input  logic [15:0]           song_key_i,
  output cple_pkg::sts_t        sts_o,
  output logic [1:0]            status_o,
  output logic [15:0]           current_key_o,
  output logic                  current_present_o,
  output logic [6:0]            entry_count_o
);
  import cple_pkg::*;

  action_e act_q;
  key_t    key_q;
  slot_t   head_q, cur_q, free_q;
  logic    cur_ok_q;
  count_t  cnt_q, walk_cnt_q;
  logic    used_q [PoolDepth];
  slot_t   scan_q;
  logic    found_q;
  logic [1:0]  status_q;
  logic [15:0] okey_q;
  logic        opres_q;
  logic [6:0]  ocnt_q;

  // link rams
  logic  fw_we, bw_we, k_we;
  slot_t fw_wa, bw_wa, fw_wd, bw_wd, raddr;
  slot_t fw_rd, bw_rd;
  key_t  k_rd;
  slot_t rd_addr_q;

  cple_ram #(.Width(SlotBits), .Depth(PoolDepth)) u_fw (
    .clk_i, .we_i(fw_we), .waddr_i(fw_wa), .wdata_i(fw_wd),
    .raddr_i(raddr), .rdata_o(fw_rd));
  cple_ram #(.Width(SlotBits), .Depth(PoolDepth)) u_bw (
    .clk_i, .we_i(bw_we), .waddr_i(bw_wa), .wdata_i(bw_wd),
    .raddr_i(raddr), .rdata_o(bw_rd));
  cple_ram #(.Width(KeyBits), .Depth(PoolDepth)) u_key (
    .clk_i, .we_i(k_we), .waddr_i(free_q), .wdata_i(key_q),
    .raddr_i(raddr), .rdata_o(k_rd));

  always_comb begin
    raddr = rd_addr_q;
    case (cmd_i.op)
      OpRdHead: raddr = head_q;
      OpRdCur:  raddr = cur_q;
      // follow the forward link of the node on the ram outputs
      OpRdNode: raddr = fw_rd;
      default:  raddr = rd_addr_q;
    endcase
  end

  // rd_addr_q tracks the slot whose data is on the ram outputs
  always_ff @(posedge clk_i) begin
    rd_addr_q <= raddr;
  end

  always_comb begin
    fw_we = 1'b0; bw_we = 1'b0; k_we = 1'b0;
    fw_wa = free_q; bw_wa = free_q; fw_wd = free_q; bw_wd = free_q;
    case (cmd_i.op)
      OpInsEmpty: begin
        fw_we = 1'b1; bw_we = 1'b1; k_we = 1'b1;
      end
      OpInsLink1: begin
        // ram output holds head: fw_rd unused, bw_rd = tail
        k_we = 1'b1; bw_we = 1'b1; bw_wd = bw_rd;
        fw_we = 1'b1; fw_wa = bw_rd; fw_wd = free_q;
      end
      OpInsLink2: begin
        bw_we = 1'b1; bw_wa = head_q; bw_wd = free_q;
        fw_we = 1'b1; fw_wa = free_q; fw_wd = head_q;
      end
      OpDelLink1: begin
        fw_we = 1'b1; fw_wa = bw_rd; fw_wd = fw_rd;
      end
      OpDelLink2: begin
        bw_we = 1'b1; bw_wa = fw_rd; bw_wd = bw_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpLatch) begin
      act_q <= action_e'(action_i);
      key_q <= song_key_i[KeyBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; cur_q <= '0; cur_ok_q <= 1'b0; cnt_q <= '0;
      scan_q <= '0; found_q <= 1'b0; free_q <= '0;
      walk_cnt_q <= '0;
      status_q <= '0; okey_q <= '0; opres_q <= 1'b0; ocnt_q <= '0;
      for (int i = 0; i < PoolDepth; i++) used_q[i] <= 1'b0;
    end else begin
      case (cmd_i.op)
        OpLatch: begin
          scan_q <= '0; found_q <= 1'b0;
        end
        OpScanStep: begin
          if (!found_q && !used_q[scan_q]) begin
            found_q <= 1'b1; free_q <= scan_q;
          end
          scan_q <= scan_q + 1'b1;
        end
        OpRdHead: walk_cnt_q <= count_t'(1);
        OpRdNode: walk_cnt_q <= walk_cnt_q + 1'b1;
        OpInsEmpty: begin
          used_q[free_q] <= 1'b1; head_q <= free_q; cur_q <= free_q;
          cur_ok_q <= 1'b1; cnt_q <= cnt_q + 1'b1;
        end
        OpInsLink2: begin
          used_q[free_q] <= 1'b1; cnt_q <= cnt_q + 1'b1;
          if (act_q == ActInsFront) head_q <= free_q;
        end
        OpStepFwd: cur_q <= fw_rd;
        OpStepBwd: cur_q <= bw_rd;
        OpSelHit: begin
          cur_q <= rd_addr_q; cur_ok_q <= 1'b1;
        end
        OpSelMiss: cur_ok_q <= 1'b0;
        OpDelLast: begin
          used_q[cur_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
          cur_ok_q <= 1'b0; head_q <= '0; cur_q <= '0;
        end
        OpDelLink2: begin
          used_q[cur_q] <= 1'b0; cnt_q <= cnt_q - 1'b1;
          if (head_q == cur_q) head_q <= fw_rd;
          cur_q <= bw_rd;
        end
        default: ;
      endcase
      // output key read: controller issues OpRdCur before out_load
      if (cmd_i.out_load) begin
        status_q <= cmd_i.status;
        okey_q   <= cur_ok_q ? 16'(k_rd) : '0;
        opres_q  <= cur_ok_q;
        ocnt_q   <= 7'(cnt_q);
      end
    end
  end

  assign sts_o.free_found = found_q;
  assign sts_o.scan_done  = (scan_q == slot_t'(PoolDepth - 1));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.cur_ok     = cur_ok_q;
  assign sts_o.key_match  = (k_rd == key_q);
  assign sts_o.walk_done  = (walk_cnt_q == cnt_q);
  assign sts_o.only_one   = (cnt_q == count_t'(1));
  assign sts_o.action     = act_q;

  assign status_o          = status_q;
  assign current_key_o     = okey_q;
  assign current_present_o = opres_q;
  assign entry_count_o     = ocnt_q;
endmodule

@@ sv/cple_ctrl.sv @@
module cple_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  cple_pkg::sts_t sts_i,
  output cple_pkg::cmd_t cmd_o
);
  import cple_pkg::*;

  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SDisp   = 11'b00000000010,
    SScan   = 11'b00000000100,
    SInsHd  = 11'b00000001000,
    SInsL2  = 11'b00000010000,
    SWalk   = 11'b00000100000,
    SCmp    = 11'b00001000000,
    SCurRd  = 11'b00010000000,
    SAct    = 11'b00100000000,
    SFinRd  = 11'b01000000000,
    SFin    = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] st_q, st_d;
  logic ovalid_q, ovalid_d;
  logic fin_q;

  assign in_ready_o  = (state_q == SIdle) && !ovalid_q && !fin_q;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q; st_d = st_q; ovalid_d = ovalid_q;
    cmd_o.op = OpNone; cmd_o.out_load = 1'b0; cmd_o.status = st_q;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      SIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.op = OpLatch; state_d = SDisp; st_d = StOk;
      end
      SDisp: begin
        case (sts_i.action)
          ActInsFront, ActInsBack: begin
            cmd_o.op = OpScanStep; state_d = SScan;
          end
          ActSelect: begin
            if (sts_i.empty) begin st_d = StEmpty; state_d = SFinRd; end
            else begin cmd_o.op = OpRdHead; state_d = SWalk; end
          end
          default: begin
            if (!sts_i.cur_ok) begin st_d = StEmpty; state_d = SFinRd; end
            else begin cmd_o.op = OpRdCur; state_d = SAct; end
          end
        endcase
      end
      SScan: begin
        if (sts_i.free_found) begin
          if (sts_i.empty) begin cmd_o.op = OpInsEmpty; state_d = SFinRd; end
          else begin cmd_o.op = OpRdHead; state_d = SInsHd; end
        end else if (sts_i.scan_done) begin
          cmd_o.op = OpScanStep; state_d = SCurRd;
        end else cmd_o.op = OpScanStep;
      end
      SCurRd: begin
        if (sts_i.free_found) begin
          if (sts_i.empty) begin cmd_o.op = OpInsEmpty; state_d = SFinRd; end
          else begin cmd_o.op = OpRdHead; state_d = SInsHd; end
        end else begin st_d = StFull; state_d = SFinRd; end
      end
      SInsHd: begin cmd_o.op = OpInsLink1; state_d = SInsL2; end
      SInsL2: begin cmd_o.op = OpInsLink2; state_d = SFinRd; end
      SWalk, SCmp: begin
        // ram holds node data; compare, then stop after the last node
        if (sts_i.key_match) begin
          cmd_o.op = OpSelHit; state_d = SFinRd;
        end else if (sts_i.walk_done) begin
          cmd_o.op = OpSelMiss; st_d = StNotFound; state_d = SFinRd;
        end else begin
          cmd_o.op = OpRdNode; state_d = SCmp;
        end
      end
      SAct: begin
        state_d = SFinRd;
        case (sts_i.action)
          ActNext: cmd_o.op = OpStepFwd;
          ActPrev: cmd_o.op = OpStepBwd;
          ActDelete: begin
            if (sts_i.only_one) cmd_o.op = OpDelLast;
            else begin cmd_o.op = OpDelLink1; state_d = SFin; end
          end
          default: ;
        endcase
      end
      SFin: begin cmd_o.op = OpDelLink2; state_d = SFinRd; end
      SFinRd: begin cmd_o.op = OpRdCur; state_d = SIdle; end
      default: state_d = SIdle;
    endcase
    if (state_q == SFinRd) begin
      state_d = SIdle;
    end
    // deliver result the cycle after the final current read
    if (state_q == SIdle && fin_q) begin
      cmd_o.out_load = 1'b1; ovalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; st_q <= StOk; ovalid_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      state_q <= state_d; st_q <= st_d; ovalid_q <= ovalid_d;
      fin_q <= (state_q == SFinRd);
    end
  end
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import cple_pkg::*;

  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    action_e action;
    key_t    key;
  } request_t;

  typedef struct packed {
    status_e status;
    key_t    cur_key;
    logic    cur_present;
    count_t  count;
  } reply_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [2:0]  action_i;
  logic [15:0] song_key_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [15:0] current_key_o;
  logic        current_present_o;
  logic [6:0]  entry_count_o;

  circular_playlist_list_engine_core dut (.*);

  // playlist shadow
  key_t   key_mem [PoolDepth];
  slot_t  fwd_mem [PoolDepth];
  slot_t  bwd_mem [PoolDepth];
  logic   used_mem [PoolDepth];
  slot_t  head_q, cur_q;
  logic   cur_valid;
  count_t songs;

  request_t pending_q[$];
  reply_t   replies_q[$];
  int       send_idle_pct, recv_idle_pct;
  int       mismatches, results_seen, stall_cycles;
  bit       stim_done;
  key_t     recent_keys[$];

  function automatic status_e playlist_insert(key_t key, logic at_front);
    slot_t s, t;
    for (int i = 0; i < PoolDepth; i++) begin
      if (!used_mem[i]) begin
        s = slot_t'(i);
        key_mem[s] = key;
        used_mem[s] = 1'b1;
        if (songs == 0) begin
          fwd_mem[s] = s; bwd_mem[s] = s;
          head_q = s; cur_q = s; cur_valid = 1'b1;
        end else begin
          t = bwd_mem[head_q];
          fwd_mem[s] = head_q; bwd_mem[s] = t;
          fwd_mem[t] = s; bwd_mem[head_q] = s;
          if (at_front) head_q = s;
        end
        songs++;
        return StOk;
      end
    end
    return StFull;
  endfunction

  function automatic reply_t playlist_step(request_t rq);
    reply_t r;
    slot_t n, p, c;
    status_e st;
    st = StOk;
    case (rq.action)
      ActInsFront: st = playlist_insert(rq.key, 1'b1);
      ActInsBack:  st = playlist_insert(rq.key, 1'b0);
      ActSelect: begin
        if (songs == 0) st = StEmpty;
        else begin
          n = head_q;
          st = StNotFound;
          for (int i = 0; i < songs; i++) begin
            if (key_mem[n] == rq.key) begin
              cur_q = n; cur_valid = 1'b1; st = StOk;
              break;
            end
            n = fwd_mem[n];
          end
          if (st == StNotFound) cur_valid = 1'b0;
        end
      end
      ActNext: if (!cur_valid) st = StEmpty; else cur_q = fwd_mem[cur_q];
      ActPrev: if (!cur_valid) st = StEmpty; else cur_q = bwd_mem[cur_q];
      ActDelete: begin
        if (!cur_valid || songs == 0) st = StEmpty;
        else begin
          c = cur_q;
          used_mem[c] = 1'b0;
          songs--;
          if (songs == 0) begin
            cur_valid = 1'b0; head_q = '0; cur_q = '0;
          end else begin
            p = bwd_mem[c]; n = fwd_mem[c];
            fwd_mem[p] = n; bwd_mem[n] = p;
            if (head_q == c) head_q = n;
            cur_q = p;
          end
        end
      end
      default: if (!cur_valid) st = StEmpty;
    endcase
    r.status = st;
    r.cur_key = cur_valid ? key_mem[cur_q] : '0;
    r.cur_present = cur_valid;
    r.count = songs;
    return r;
  endfunction

  task automatic push_req(action_e a, key_t k);
    request_t rq;
    rq.action = a;
    rq.key = k;
    pending_q.push_back(rq);
  endtask

  function automatic key_t pick_key();
    // favor ids already in use so selects hit and duplicates appear
    if (recent_keys.size() > 0 && $urandom_range(0, 2) != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    return $urandom_range(0, 3) == 0 ? key_t'($urandom) : key_t'($urandom_range(0, 15));
  endfunction

  task automatic fill_random(int n);
    key_t k;
    int w;
    for (int i = 0; i < n; i++) begin
      k = pick_key();
      w = $urandom_range(0, 99);
      if (w < 30) begin
        push_req($urandom_range(0, 1) ? ActInsFront : ActInsBack, k);
        recent_keys.push_back(k);
        if (recent_keys.size() > 16) void'(recent_keys.pop_front());
      end else if (w < 45) push_req(ActSelect, k);
      else if (w < 60) push_req(ActNext, key_t'($urandom));
      else if (w < 72) push_req(ActPrev, key_t'($urandom));
      else if (w < 92) push_req(ActDelete, key_t'($urandom));
      else push_req($urandom_range(0, 1) ? ActRead : ActSpare, key_t'($urandom));
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      action_i <= '0;
      song_key_i <= '0;
    end else begin
      if (!in_valid_i || in_ready_o) begin
        if (in_valid_i) replies_q.push_back(playlist_step({action_e'(action_i), song_key_i}));
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          {action_i, song_key_i} <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (replies_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          reply_t e;
          e = replies_q.pop_front();
          if (status_o !== e.status || current_key_o !== e.cur_key ||
              current_present_o !== e.cur_present || entry_count_o !== e.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch #%0d: exp st=%0d key=%h cur=%0b cnt=%0d got st=%0d key=%h cur=%0b cnt=%0d",
                       results_seen, e.status, e.cur_key, e.cur_present, e.count,
                       status_o, current_key_o, current_present_o, entry_count_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    mismatches = 0;
    results_seen = 0;
    stall_cycles = 0;
    stim_done = 0;
    send_idle_pct = 15;
    recv_idle_pct = 83;
    for (int i = 0; i < PoolDepth; i++) used_mem[i] = 1'b0;
    head_q = '0; cur_q = '0; cur_valid = 1'b0; songs = '0;
    // empty-list handling of every non-insert action
    push_req(ActRead, 16'h0000);
    push_req(ActNext, 16'hffff);
    push_req(ActPrev, 16'h0000);
    push_req(ActDelete, 16'h0000);
    push_req(ActSelect, 16'hffff);
    push_req(ActSpare, 16'h0000);
    // first insert becomes current; then front, back, duplicate ids
    push_req(ActInsBack, 16'hffff);
    push_req(ActInsFront, 16'h0000);
    push_req(ActInsBack, 16'h1234);
    push_req(ActInsFront, 16'h1234);
    push_req(ActNext, 16'h0);
    push_req(ActPrev, 16'h0);
    push_req(ActSelect, 16'h1234);
    push_req(ActSelect, 16'h5555);
    push_req(ActRead, 16'h0);
    push_req(ActSelect, 16'h0000);
    push_req(ActDelete, 16'h0);
    push_req(ActSelect, 16'hffff);
    push_req(ActDelete, 16'h0);
    push_req(ActDelete, 16'h0);
    push_req(ActDelete, 16'h0);
    push_req(ActDelete, 16'h0);
    push_req(ActRead, 16'h0);
    // fill the pool past full
    for (int i = 0; i < PoolDepth + 2; i++) push_req(ActInsBack, key_t'(i * 997));
    push_req(ActSelect, key_t'(5 * 997));
    fill_random(450);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0);
    send_idle_pct = 83;
    recv_idle_pct = 15;
    fill_random(500);
    wait (pending_q.size() == 0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(500);
    wait (pending_q.size() == 0 && !in_valid_i);
    wait (replies_q.size() == 0);
    repeat (80) @(posedge clk_i);
    stim_done = 1;
  end

  initial begin
    wait (stim_done || stall_cycles >= StallLimit);
    $display("covered %0d result words over empty, single, duplicate and full playlists",
             results_seen);
    $display("with sender and receiver stalls in three idling phases");
    if (stim_done && mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, stalled=%0b", mismatches, !stim_done);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
